### hw/rtl/mbp_pkg.sv
// Shared types and constants for the multipart boundary parser.
// Used by the front end, the op queue, the parse engine, the top level and the checker.
package mbp_pkg;

    localparam int MAX_DELIMITER = 128;
    localparam int STORE_AW      = $clog2(MAX_DELIMITER);
    localparam int LEN_W         = 8;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_BODY  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        EV_ACK      = 4'd0,
        EV_DATA     = 4'd1,
        EV_DELIM    = 4'd2,
        EV_CRLF     = 4'd3,
        EV_HDR_BYTE = 4'd4,
        EV_HDR_LINE = 4'd5,
        EV_HDRS_END = 4'd6,
        EV_CLOSING  = 4'd7,
        EV_ERROR    = 4'd8
    } event_t;

    typedef enum logic [3:0] {
        PH_FIND       = 4'd0,
        PH_END_CR     = 4'd1,
        PH_END_LF     = 4'd2,
        PH_LINE_START = 4'd3,
        PH_IN_HEADER  = 4'd4,
        PH_HEADER_LF  = 4'd5,
        PH_BLANK_LF   = 4'd6,
        PH_DONE       = 4'd7,
        PH_ERROR      = 4'd8
    } phase_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [LEN_W-1:0]    len;
        logic [STORE_AW-1:0] idx;
        logic                idx_ok;
        logic                idx_zero;
        logic [7:0]          data;
        logic                is_cr;
        logic                is_lf;
        logic                is_dash;
    } op_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        logic [7:0] cnt;
    } res_t;

endpackage

### hw/rtl/mbp_front.sv
// Front end: accepts input beats, clamps and decodes them into queue ops.
// Depends on mbp_pkg.
module mbp_front import mbp_pkg::*; (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output op_t         q_op
);

    logic [LEN_W-1:0] len_raw;
    logic [6:0]       idx_raw;
    logic [7:0]       byte_raw;

    assign len_raw  = s_tdata[7:0];
    assign idx_raw  = s_tdata[14:8];
    assign byte_raw = s_tdata[22:15];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_op          = '0;
        q_op.cmd      = cmd_t'(s_tuser);
        q_op.data     = byte_raw;
        q_op.idx      = STORE_AW'(idx_raw);
        q_op.idx_ok   = (int'(idx_raw) < MAX_DELIMITER);
        q_op.idx_zero = (idx_raw == '0);
        q_op.is_cr    = (byte_raw == CH_CR);
        q_op.is_lf    = (byte_raw == CH_LF);
        q_op.is_dash  = (byte_raw == CH_DASH);
        if (len_raw == '0) begin
            q_op.len = LEN_W'(1);
        end else if (int'(len_raw) > MAX_DELIMITER) begin
            q_op.len = LEN_W'(MAX_DELIMITER);
        end else begin
            q_op.len = len_raw;
        end
    end

endmodule

### hw/rtl/mbp_fifo.sv
// Short op queue between the front end and the parse engine.
// Depends on mbp_pkg.
module mbp_fifo import mbp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  op_t  wr_op,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output op_t  rd_op
);

    op_t                entries_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full     = (int'(count_reg) == FIFO_DEPTH);
    assign rd_valid = (count_reg != '0);
    assign rd_op    = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_en && !(rd_en && rd_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!wr_en && rd_en && rd_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en && rd_valid) begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

### hw/rtl/mbp_engine.sv
// Parse engine: delimiter store, match tracking, phase machine and output register.
// Depends on mbp_pkg.
module mbp_engine import mbp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic op_valid,
    input  op_t  op,
    output logic op_pop,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    logic [7:0]          store_mem [MAX_DELIMITER];
    logic [7:0]          rd_data_reg;
    logic [7:0]          first_reg;
    logic [7:0]          first_next;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [STORE_AW-1:0] pos_reg;
    logic [STORE_AW-1:0] pos_next;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic [STORE_AW:0]   pos_try;
    logic                wr_en;
    logic                fire;
    logic                m_valid_reg;
    res_t                res_reg;
    res_t                res_next;

    assign fire    = op_valid && (!m_valid_reg || m_ready);
    assign op_pop  = fire;
    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        first_next    = first_reg;
        wr_en         = 1'b0;
        pos_try       = '0;
        res_next.ev   = EV_ACK;
        res_next.data = '0;
        res_next.cnt  = '0;
        if (fire) begin
            case (op.cmd)
                CMD_START: begin
                    len_next   = op.len;
                    phase_next = PH_FIND;
                    pos_next   = '0;
                end
                CMD_LOAD: begin
                    wr_en = op.idx_ok;
                    if (op.idx_ok && op.idx_zero) begin
                        first_next = op.data;
                    end
                end
                CMD_BODY: begin
                    res_next.data = op.data;
                    case (phase_reg)
                        PH_FIND: begin
                            if (op.data == rd_data_reg) begin
                                pos_try = {1'b0, pos_reg} + 1'b1;
                            end else if (op.data == first_reg) begin
                                pos_try = (STORE_AW + 1)'(1);
                            end else begin
                                pos_try = '0;
                            end
                            if (int'(pos_try) >= int'(len_reg)) begin
                                res_next.ev  = EV_DELIM;
                                res_next.cnt = 8'(len_reg);
                                pos_next     = '0;
                                phase_next   = PH_END_CR;
                            end else begin
                                res_next.ev  = EV_DATA;
                                res_next.cnt = 8'(pos_try);
                                pos_next     = pos_try[STORE_AW-1:0];
                            end
                        end
                        PH_END_CR: begin
                            res_next.ev = op.is_cr ? EV_CRLF : EV_ERROR;
                            phase_next  = op.is_cr ? PH_END_LF : PH_ERROR;
                        end
                        PH_END_LF: begin
                            res_next.ev = op.is_lf ? EV_CRLF : EV_ERROR;
                            phase_next  = op.is_lf ? PH_LINE_START : PH_ERROR;
                        end
                        PH_LINE_START: begin
                            if (op.is_cr) begin
                                res_next.ev = EV_HDRS_END;
                                phase_next  = PH_BLANK_LF;
                            end else if (op.is_dash) begin
                                res_next.ev = EV_CLOSING;
                                phase_next  = PH_DONE;
                            end else begin
                                res_next.ev = EV_HDR_BYTE;
                                phase_next  = PH_IN_HEADER;
                            end
                        end
                        PH_IN_HEADER: begin
                            if (op.is_cr) begin
                                res_next.ev = EV_HDR_LINE;
                                phase_next  = PH_HEADER_LF;
                            end else begin
                                res_next.ev = EV_HDR_BYTE;
                            end
                        end
                        PH_HEADER_LF: begin
                            res_next.ev = op.is_lf ? EV_HDR_LINE : EV_ERROR;
                            phase_next  = op.is_lf ? PH_LINE_START : PH_ERROR;
                        end
                        PH_BLANK_LF: begin
                            if (op.is_lf) begin
                                res_next.ev = EV_HDRS_END;
                                phase_next  = PH_FIND;
                                pos_next    = '0;
                            end else begin
                                res_next.ev = EV_ERROR;
                                phase_next  = PH_ERROR;
                            end
                        end
                        PH_DONE: begin
                            res_next.ev = EV_CLOSING;
                        end
                        default: begin
                            res_next.ev = EV_ERROR;
                            phase_next  = PH_ERROR;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIND;
            pos_reg     <= '0;
            len_reg     <= LEN_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // prefetch the store byte at the next match position, bypass a same-cycle load
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[op.idx] <= op.data;
        end
        if (wr_en && (op.idx == pos_next)) begin
            rd_data_reg <= op.data;
        end else begin
            rd_data_reg <= store_mem[pos_next];
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule

### hw/rtl/multipart_boundary_parser.sv
// Top level of the multipart boundary parser.
// Depends on mbp_pkg, mbp_front, mbp_fifo and mbp_engine.
//
// Takes one beat per cycle while the op queue has room and returns exactly one result beat
// per input beat, in order; a result passes through the op queue and then the output
// register before it can be taken. The
// rate is set by the delimiter store read: the byte at the next match position is
// prefetched into a register every cycle, so each body byte needs one compare against
// that register and the stored first byte. A two-entry queue and an output register let
// input and output stall independently. The store needs no clearing pass after reset;
// delimiter bytes must be loaded before body bytes are scanned against them.
module multipart_boundary_parser import mbp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // delimiter_length[7:0], delimiter_index[14:8], byte_in[22:15]
    input  logic [1:0]  s_tuser,  // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // byte_out[7:0], matched_count[15:8]
    output logic [3:0]  m_tuser   // event_res[3:0]
);

    logic q_full;
    logic q_push;
    op_t  q_wr_op;
    logic q_pop;
    logic q_valid;
    op_t  q_rd_op;
    res_t res;

    mbp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_wr_op)
    );

    mbp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_op    (q_wr_op),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_op    (q_rd_op)
    );

    mbp_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (q_valid),
        .op       (q_rd_op),
        .op_pop   (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {res.cnt, res.data};
    assign m_tuser = res.ev;

endmodule

### hw/rtl/mbp_checker.sv
// Port-level checker for the multipart boundary parser, bound to the top level.
// Depends on mbp_pkg and multipart_boundary_parser.
module mbp_checker import mbp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser
);

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tuser) <= int'(EV_ERROR)))
        else $error("event code out of range");

    a_ack_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_ACK)) |-> (m_tdata == '0))
        else $error("ack beat carries data");

    a_count_scan_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != EV_DATA) && (m_tuser != EV_DELIM)) |-> (m_tdata[15:8] == '0))
        else $error("match count outside scanning");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind multipart_boundary_parser mbp_checker u_mbp_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for multipart_boundary_parser: directed parses, then random
// multipart messages with random stalls on both sides, checked beat by beat.
// Depends on mbp_pkg and the multipart_boundary_parser RTL.
module tb_top;
    import mbp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // delimiter_length[7:0], delimiter_index[14:8], byte_in[22:15]
    logic [1:0]  s_tuser;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // byte_out[7:0], matched_count[15:8]
    logic [3:0]  m_tuser;   // event_res[3:0]

    multipart_boundary_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    phase_t      cur_phase = PH_FIND;
    int unsigned cur_match = 0;
    int unsigned cur_len   = 1;
    logic [7:0]  delim_bytes [MAX_DELIMITER];

    res_t pending_events[$];
    int   fail_count = 0;
    int   beats_sent = 0;
    bit   throttle   = 1'b1;

    function automatic res_t classify_beat(cmd_t cmd, logic [7:0] len, logic [6:0] idx,
                                           logic [7:0] b);
        res_t        r;
        int unsigned pos;
        r.ev   = EV_ACK;
        r.data = 8'd0;
        r.cnt  = 8'd0;
        case (cmd)
            CMD_START: begin
                cur_len   = (len == 0) ? 1 : ((len > MAX_DELIMITER) ? MAX_DELIMITER : len);
                cur_phase = PH_FIND;
                cur_match = 0;
            end
            CMD_LOAD: begin
                delim_bytes[idx] = b;
            end
            CMD_BODY: begin
                r.data = b;
                case (cur_phase)
                    PH_FIND: begin
                        if (b == delim_bytes[cur_match])
                            pos = cur_match + 1;
                        else
                            pos = (b == delim_bytes[0]) ? 1 : 0;
                        if (pos >= cur_len) begin
                            r.ev      = EV_DELIM;
                            r.cnt     = 8'(cur_len);
                            cur_match = 0;
                            cur_phase = PH_END_CR;
                        end else begin
                            r.ev      = EV_DATA;
                            r.cnt     = 8'(pos);
                            cur_match = pos;
                        end
                    end
                    PH_END_CR: begin
                        if (b == CH_CR) begin
                            r.ev = EV_CRLF;
                            cur_phase = PH_END_LF;
                        end else begin
                            r.ev = EV_ERROR;
                            cur_phase = PH_ERROR;
                        end
                    end
                    PH_END_LF: begin
                        if (b == CH_LF) begin
                            r.ev = EV_CRLF;
                            cur_phase = PH_LINE_START;
                        end else begin
                            r.ev = EV_ERROR;
                            cur_phase = PH_ERROR;
                        end
                    end
                    PH_LINE_START: begin
                        if (b == CH_CR) begin
                            r.ev = EV_HDRS_END;
                            cur_phase = PH_BLANK_LF;
                        end else if (b == CH_DASH) begin
                            r.ev = EV_CLOSING;
                            cur_phase = PH_DONE;
                        end else begin
                            r.ev = EV_HDR_BYTE;
                            cur_phase = PH_IN_HEADER;
                        end
                    end
                    PH_IN_HEADER: begin
                        if (b == CH_CR) begin
                            r.ev = EV_HDR_LINE;
                            cur_phase = PH_HEADER_LF;
                        end else begin
                            r.ev = EV_HDR_BYTE;
                        end
                    end
                    PH_HEADER_LF: begin
                        if (b == CH_LF) begin
                            r.ev = EV_HDR_LINE;
                            cur_phase = PH_LINE_START;
                        end else begin
                            r.ev = EV_ERROR;
                            cur_phase = PH_ERROR;
                        end
                    end
                    PH_BLANK_LF: begin
                        if (b == CH_LF) begin
                            r.ev = EV_HDRS_END;
                            cur_phase = PH_FIND;
                            cur_match = 0;
                        end else begin
                            r.ev = EV_ERROR;
                            cur_phase = PH_ERROR;
                        end
                    end
                    PH_DONE: begin
                        r.ev = EV_CLOSING;
                    end
                    default: begin
                        r.ev = EV_ERROR;
                        cur_phase = PH_ERROR;
                    end
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("[multipart_boundary_parser] ERROR");
        $finish;
    end

    task automatic send_beat(input cmd_t cmd, input logic [7:0] len, input logic [6:0] idx,
                             input logic [7:0] b);
        int gap;
        gap = throttle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, b, idx, len};
        do @(posedge aclk); while (!s_tready);
        pending_events.push_back(classify_beat(cmd, len, idx, b));
        beats_sent++;
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = throttle ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("result beat with no expectation: event_res %0d", m_tuser);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_tuser !== want.ev) begin
                    $error("event_res: expected %0d, actual %0d", want.ev, m_tuser);
                    fail_count++;
                end
                if (m_tdata[7:0] !== want.data) begin
                    $error("byte_out: expected %0d, actual %0d", want.data, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== want.cnt) begin
                    $error("matched_count: expected %0d, actual %0d", want.cnt, m_tdata[15:8]);
                    fail_count++;
                end
            end
        end
    end

    // Reset length is one: a single dash delimiter, full part, then the closing dash.
    task automatic test_reset_parse();
        send_beat(CMD_LOAD, 8'h00, 7'd0, CH_DASH);
        send_beat(CMD_BODY, 8'h00, 7'd0, "x");
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_DASH);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_CR);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_LF);
        send_beat(CMD_BODY, 8'h00, 7'd0, "H");
        send_beat(CMD_BODY, 8'h00, 7'd0, 8'hFF);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_CR);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_LF);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_CR);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_LF);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_DASH);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_CR);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_LF);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_DASH);
        send_beat(CMD_BODY, 8'h00, 7'd0, 8'h00);
    endtask

    // Unused command, top store index, length clamps, sticky error, match restart.
    task automatic test_edge_cases();
        send_beat(CMD_NOP, 8'hFF, 7'h7F, 8'hFF);
        send_beat(CMD_LOAD, 8'hFF, 7'd127, 8'hFF);
        send_beat(CMD_START, 8'd0, 7'd0, 8'h00);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_DASH);
        send_beat(CMD_BODY, 8'h00, 7'd0, "Z");
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_CR);
        send_beat(CMD_LOAD, 8'h00, 7'd1, "a");
        send_beat(CMD_START, 8'd2, 7'd0, 8'h00);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_DASH);
        send_beat(CMD_BODY, 8'h00, 7'd0, CH_DASH);
        send_beat(CMD_BODY, 8'h00, 7'd0, "a");
        send_beat(CMD_START, 8'd255, 7'd0, 8'h00);
    endtask

    task automatic test_random_messages();
        int         raw;
        int         eff;
        int         pick;
        int         parts_left;
        int         data_left;
        int         hdr_lines_left;
        int         hdr_chars_left;
        logic [7:0] b;
        while (beats_sent < 1950) begin
            throttle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0:       raw = $urandom_range(129, 255);
                1:       raw = 0;
                2:       raw = MAX_DELIMITER;
                default: raw = $urandom_range(1, 12);
            endcase
            eff = (raw == 0) ? 1 : ((raw > MAX_DELIMITER) ? MAX_DELIMITER : raw);
            for (int i = 0; i < eff; i++) begin
                if (i < 2 && $urandom_range(0, 19) != 0)
                    b = CH_DASH;
                else if ($urandom_range(0, 1) == 0)
                    b = 8'($urandom);
                else
                    case ($urandom_range(0, 2))
                        0:       b = CH_DASH;
                        1:       b = "a";
                        default: b = "b";
                    endcase
                send_beat(CMD_LOAD, 8'($urandom), 7'(i), b);
            end
            send_beat(CMD_START, 8'(raw), 7'($urandom), 8'($urandom));
            parts_left     = $urandom_range(0, 3);
            data_left      = $urandom_range(0, 20);
            hdr_lines_left = $urandom_range(0, 3);
            hdr_chars_left = 0;
            while (cur_phase != PH_DONE && cur_phase != PH_ERROR) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    send_beat(CMD_NOP, 8'($urandom), 7'($urandom), 8'($urandom));
                end else if (pick == 2) begin
                    send_beat(CMD_LOAD, 8'($urandom), 7'($urandom), 8'($urandom));
                end else if (pick == 3) begin
                    send_beat(CMD_START, 8'(cur_len), 7'($urandom), 8'($urandom));
                end else if (pick < 8) begin
                    send_beat(CMD_BODY, 8'($urandom), 7'($urandom), 8'($urandom));
                end else begin
                    case (cur_phase)
                        PH_FIND: begin
                            if (data_left > 0) begin
                                data_left--;
                                if ($urandom_range(0, 4) == 0)
                                    b = delim_bytes[$urandom_range(0, cur_len - 1)];
                                else
                                    b = 8'($urandom);
                            end else begin
                                b = delim_bytes[cur_match];
                            end
                        end
                        PH_END_CR: b = CH_CR;
                        PH_END_LF, PH_HEADER_LF: b = CH_LF;
                        PH_BLANK_LF: begin
                            b = CH_LF;
                            data_left      = $urandom_range(0, 24);
                            hdr_lines_left = $urandom_range(0, 3);
                        end
                        PH_LINE_START: begin
                            if (hdr_lines_left > 0) begin
                                hdr_lines_left--;
                                hdr_chars_left = $urandom_range(0, 10);
                                do b = 8'($urandom); while (b == CH_CR || b == CH_DASH);
                            end else if (parts_left > 0) begin
                                parts_left--;
                                b = CH_CR;
                            end else begin
                                b = CH_DASH;
                            end
                        end
                        PH_IN_HEADER: begin
                            if (hdr_chars_left > 0) begin
                                hdr_chars_left--;
                                do b = 8'($urandom); while (b == CH_CR);
                            end else begin
                                b = CH_CR;
                            end
                        end
                        default: b = 8'($urandom);
                    endcase
                    send_beat(CMD_BODY, 8'($urandom), 7'($urandom), b);
                end
            end
            repeat ($urandom_range(0, 3))
                send_beat(CMD_BODY, 8'($urandom), 7'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_START;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_parse();
        test_edge_cases();
        test_random_messages();

        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("[multipart_boundary_parser] OK");
        else
            $display("[multipart_boundary_parser] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mbp_pkg.sv
hw/rtl/mbp_front.sv
hw/rtl/mbp_fifo.sv
hw/rtl/mbp_engine.sv
hw/rtl/multipart_boundary_parser.sv
hw/rtl/mbp_checker.sv
tb/tb_top.sv
